// ===== sv/vas_pkg.sv =====
// shared types, codes and helpers of the voice allocator with stealing
// no dependencies; used by every module of the block
package vas_pkg;

    localparam int MAX_VOICES = 64;
    localparam int VIDX_W = $clog2(MAX_VOICES);
    localparam int VCNT_W = VIDX_W + 1;
    localparam logic [31:0] SILENCE_LEVEL_Q16 = 32'd7;
    localparam logic [31:0] ENERGY_FLOOR_Q16 = 32'd7;
    localparam logic [15:0] UNITY_GAIN_Q8 = 16'd256;

    typedef enum logic [1:0] {
        MODE_CONTACT = 2'd0,
        MODE_ENERGY  = 2'd1,
        MODE_RETIRE  = 2'd2,
        MODE_ADVANCE = 2'd3
    } mode_t;

    localparam logic [1:0] CONTACT_ROLL    = 2'd1;
    localparam logic [1:0] CONTACT_SCRAPE  = 2'd2;
    localparam logic [1:0] CONTACT_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        ST_NO_MODEL      = 4'd0,
        ST_ALL_PROTECTED = 4'd1,
        ST_REFRESHED     = 4'd2,
        ST_RELEASED      = 4'd3,
        ST_NEW_FREE      = 4'd4,
        ST_STOLEN        = 4'd5,
        ST_ENERGY        = 4'd6,
        ST_SILENCED      = 4'd7,
        ST_RETIRED       = 4'd8,
        ST_ADVANCED      = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        CFG_NEAR      = 3'd0,
        CFG_MID       = 3'd1,
        CFG_FAR       = 3'd2,
        CFG_PRESSURE  = 3'd3,
        CFG_COUNTS    = 3'd4,
        CFG_MODELS    = 3'd5,
        CFG_PROTECTED = 3'd6,
        CFG_VCOUNT    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         model_sel;
        logic [31:0]        contact_tag;
        logic [1:0]         contact_type;
        logic [15:0]        distance_cm;
        logic signed [15:0] pan_q15;
        logic [15:0]        force_q8;
        logic [31:0]        impulse_q16;
        logic [5:0]         voice_select;
        logic [31:0]        energy_q16;
        logic [15:0]        frame_step;
    } in_t;

    typedef struct packed {
        logic [3:0]         status;
        logic [5:0]         voice_index;
        logic [31:0]        tag_out;
        logic [7:0]         mode_total;
        logic [15:0]        gain_q8;
        logic signed [15:0] pan_out_q15;
        logic [31:0]        energy_out_q16;
        logic [31:0]        dropped_total;
        logic [31:0]        stolen_total;
    } out_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [63:0] start_frame;
        logic [31:0] energy;
        logic [15:0] gain;
        logic [15:0] pan;
    } voice_word_t;

    typedef struct packed {
        logic              match_found;
        logic [VIDX_W-1:0] match_idx;
        logic              free_found;
        logic [VIDX_W-1:0] free_idx;
        logic              quiet_found;
        logic [VIDX_W-1:0] quiet_idx;
        logic [31:0]       quiet_energy;
        logic [VCNT_W-1:0] active_cnt;
    } scan_res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic out_t make_result(
        input status_t          st,
        input logic [VIDX_W-1:0] idx,
        input voice_word_t      w,
        input logic             show,
        input logic [7:0]       modes,
        input logic [31:0]      dropped,
        input logic [31:0]      stolen
    );
        out_t r;
        r.status         = st;
        r.voice_index    = 6'(idx);
        r.tag_out        = show ? w.tag : 32'd0;
        r.mode_total     = modes;
        r.gain_q8        = show ? w.gain : 16'd0;
        r.pan_out_q15    = show ? w.pan : 16'd0;
        r.energy_out_q16 = show ? w.energy : 32'd0;
        r.dropped_total  = dropped;
        r.stolen_total   = stolen;
        make_result = r;
    endfunction

endpackage

// ===== sv/voice_allocator_with_stealing.sv =====
// voice allocator with quietest-voice stealing: sequencer, config, flags
// depends on vas_pkg, vas_ram, vas_scan
//
// usage:
//   command channel: an item transfers at a clock edge with start high and
//   busy low. busy stays high while an item is being worked on.
//   result channel: done pulses for one cycle with result valid; the
//   receiver must take it then, it cannot stall the block.
//   config channel: cfg_valid/cfg_ready, cfg_index selects the register,
//   cfg_data carries the value; cfg_ready is always high, write only idle.
// sequence from the transfer to done:
//   advance frames, absent model, voice outside the pool: answered from idle
//   energy report, retire: memory read, then update
//   contact event: scan of the pool, drain, decide, and an update on a tag match;
//   one voice per cycle goes through the shared scan unit
// one item at a time; the next transfer may coincide with done.
// reset: all voices inactive, state reads as zero, counters cleared,
//   config registers at their defaults. no clearing pass is needed.
module voice_allocator_with_stealing (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  vas_pkg::in_t   cmd,
    output logic           done,
    output vas_pkg::out_t  result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [63:0]    cfg_data
);
    import vas_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_DECIDE = 6'b001000,
        S_READ   = 6'b010000,
        S_UPDATE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    in_t    cmd_reg, cmd_next;
    logic [VIDX_W-1:0] idx_reg, idx_next;
    logic [VCNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              eval_vld_reg, eval_vld_next;
    logic [VIDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic [63:0] frame_reg, frame_next;
    logic [31:0] dropped_reg, dropped_next;
    logic [31:0] stolen_reg, stolen_next;
    logic [MAX_VOICES-1:0] active_reg, active_next;
    logic [MAX_VOICES-1:0] cont_reg, cont_next;
    logic [MAX_VOICES-1:0] written_reg, written_next;
    logic  written_q_reg;
    out_t  result_reg, result_next;
    logic  done_reg, done_next;

    logic [15:0] near_reg, mid_reg, far_reg;
    logic [8:0]  press_reg;
    logic [31:0] counts_reg, prot_reg;
    logic [63:0] models_reg;
    logic [6:0]  vcount_reg;

    logic [VCNT_W-1:0] pool_n;
    logic [VIDX_W-1:0] rd_addr;
    voice_word_t rd_data, rd_word, wr_word;
    logic        we;
    logic        scan_clear;
    scan_res_t   sr;
    logic [15:0] occ_lhs, occ_rhs;
    logic [1:0]  band;
    logic [7:0]  modes;
    logic [VIDX_W-1:0] alloc_idx;

    always_comb
    begin
        if (vcount_reg == 7'd0)
        begin
            pool_n = VCNT_W'(1);
        end
        else if (vcount_reg > 7'(MAX_VOICES))
        begin
            pool_n = VCNT_W'(MAX_VOICES);
        end
        else
        begin
            pool_n = VCNT_W'(vcount_reg);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg   <= 16'd500;
            mid_reg    <= 16'd2000;
            far_reg    <= 16'd5000;
            press_reg  <= 9'd230;
            counts_reg <= 32'd135274560;
            models_reg <= 64'd0;
            prot_reg   <= 32'd480;
            vcount_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NEAR:      near_reg   <= cfg_data[15:0];
                CFG_MID:       mid_reg    <= cfg_data[15:0];
                CFG_FAR:       far_reg    <= cfg_data[15:0];
                CFG_PRESSURE:  press_reg  <= cfg_data[8:0];
                CFG_COUNTS:    counts_reg <= cfg_data[31:0];
                CFG_MODELS:    models_reg <= cfg_data;
                CFG_PROTECTED: prot_reg   <= cfg_data[31:0];
                CFG_VCOUNT:    vcount_reg <= cfg_data[6:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_SCAN:   rd_addr = scan_cnt_reg[VIDX_W-1:0];
            S_DECIDE: rd_addr = sr.match_idx;
            default:  rd_addr = idx_reg;
        endcase
    end

    vas_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx_next),
        .wdata (wr_word),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        written_q_reg <= written_reg[rd_addr];
    end

    // never-allocated entries read as zero
    assign rd_word = written_q_reg ? rd_data : '0;

    vas_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (scan_clear),
        .eval   (eval_vld_reg),
        .idx    (eval_idx_reg),
        .active (active_reg[eval_idx_reg]),
        .word   (rd_word),
        .hint   (cmd_reg.contact_tag),
        .frame  (frame_reg),
        .prot   (prot_reg),
        .res    (sr)
    );

    // mode count from pool pressure and distance bands
    always_comb
    begin
        occ_lhs = {1'b0, sr.active_cnt, 8'd0};
        occ_rhs = 16'(press_reg * pool_n);
        priority if (occ_lhs > occ_rhs)
        begin
            band = 2'd3;
        end
        else if (cmd_reg.distance_cm < near_reg)
        begin
            band = 2'd0;
        end
        else if (cmd_reg.distance_cm < mid_reg)
        begin
            band = 2'd1;
        end
        else if (cmd_reg.distance_cm < far_reg)
        begin
            band = 2'd2;
        end
        else
        begin
            band = 2'd3;
        end
        modes = counts_reg[{band, 3'b000} +: 8];
        alloc_idx = sr.free_found ? sr.free_idx : sr.quiet_idx;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        scan_cnt_next = scan_cnt_reg;
        eval_vld_next = 1'b0;
        eval_idx_next = eval_idx_reg;
        frame_next    = frame_reg;
        dropped_next  = dropped_reg;
        stolen_next   = stolen_reg;
        active_next   = active_reg;
        cont_next     = cont_reg;
        written_next  = written_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        we            = 1'b0;
        wr_word       = rd_word;
        scan_clear    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    unique case (mode_t'(cmd.mode))
                        MODE_CONTACT:
                        begin
                            if (!models_reg[cmd.model_sel])
                            begin
                                dropped_next = sat_inc(dropped_reg);
                                result_next  = make_result(ST_NO_MODEL, '0, '0, 1'b0,
                                    8'd0, dropped_next, stolen_reg);
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                scan_clear    = 1'b1;
                                scan_cnt_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        MODE_ADVANCE:
                        begin
                            frame_next  = frame_reg + {48'd0, cmd.frame_step};
                            result_next = make_result(ST_ADVANCED, '0, '0, 1'b0, 8'd0,
                                dropped_reg, stolen_reg);
                            done_next   = 1'b1;
                        end
                        MODE_ENERGY, MODE_RETIRE:
                        begin
                            if (VCNT_W'(cmd.voice_select) >= pool_n)
                            begin
                                result_next = make_result(
                                    (cmd.mode == MODE_ENERGY) ? ST_ENERGY : ST_RETIRED,
                                    VIDX_W'(cmd.voice_select), '0, 1'b0, 8'd0,
                                    dropped_reg, stolen_reg);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = VIDX_W'(cmd.voice_select);
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                eval_vld_next = 1'b1;
                eval_idx_next = scan_cnt_reg[VIDX_W-1:0];
                scan_cnt_next = scan_cnt_reg + VCNT_W'(1);
                if (scan_cnt_reg == pool_n - VCNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (sr.match_found)
                begin
                    idx_next = sr.match_idx;
                    if (cmd_reg.contact_type == CONTACT_RELEASE)
                    begin
                        cont_next[sr.match_idx] = 1'b0;
                    end
                    state_next = S_UPDATE;
                end
                else if (sr.free_found || sr.quiet_found)
                begin
                    idx_next = alloc_idx;
                    if (!sr.free_found)
                    begin
                        stolen_next = sat_inc(stolen_reg);
                    end
                    wr_word.tag         = cmd_reg.contact_tag;
                    wr_word.start_frame = frame_reg;
                    wr_word.gain        = UNITY_GAIN_Q8;
                    wr_word.pan         = cmd_reg.pan_q15;
                    wr_word.energy      = (cmd_reg.impulse_q16 > ENERGY_FLOOR_Q16) ?
                        cmd_reg.impulse_q16 : ENERGY_FLOOR_Q16;
                    we = 1'b1;
                    written_next[alloc_idx] = 1'b1;
                    active_next[alloc_idx]  = 1'b1;
                    cont_next[alloc_idx]    = (cmd_reg.contact_type == CONTACT_ROLL) ||
                        (cmd_reg.contact_type == CONTACT_SCRAPE);
                    result_next = make_result(sr.free_found ? ST_NEW_FREE : ST_STOLEN,
                        alloc_idx, wr_word, 1'b1, modes, dropped_reg, stolen_next);
                    // tagless starts report tag one
                    result_next.tag_out = (cmd_reg.contact_tag != 32'd0) ?
                        cmd_reg.contact_tag : 32'd1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    dropped_next = sat_inc(dropped_reg);
                    result_next  = make_result(ST_ALL_PROTECTED, '0, '0, 1'b0, 8'd0,
                        dropped_next, stolen_reg);
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                unique case (mode_t'(cmd_reg.mode))
                    MODE_CONTACT:
                    begin
                        if (cmd_reg.contact_type == CONTACT_RELEASE)
                        begin
                            result_next = make_result(ST_RELEASED, idx_reg, rd_word, 1'b1,
                                8'd0, dropped_reg, stolen_reg);
                        end
                        else
                        begin
                            wr_word.gain = cmd_reg.force_q8;
                            wr_word.pan  = cmd_reg.pan_q15;
                            we = 1'b1;
                            result_next = make_result(ST_REFRESHED, idx_reg, wr_word, 1'b1,
                                8'd0, dropped_reg, stolen_reg);
                        end
                    end
                    MODE_ENERGY:
                    begin
                        result_next = make_result(ST_ENERGY, idx_reg, rd_word, 1'b1,
                            8'd0, dropped_reg, stolen_reg);
                        if (active_reg[idx_reg])
                        begin
                            wr_word.energy = cmd_reg.energy_q16;
                            we = 1'b1;
                            result_next = make_result(ST_ENERGY, idx_reg, wr_word, 1'b1,
                                8'd0, dropped_reg, stolen_reg);
                            if (!cont_reg[idx_reg] && cmd_reg.energy_q16 < SILENCE_LEVEL_Q16)
                            begin
                                active_next[idx_reg] = 1'b0;
                                result_next.status   = ST_SILENCED;
                            end
                        end
                    end
                    default:
                    begin
                        active_next[idx_reg] = 1'b0;
                        result_next = make_result(ST_RETIRED, idx_reg, rd_word, 1'b1,
                            8'd0, dropped_reg, stolen_reg);
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            eval_vld_reg <= 1'b0;
            frame_reg    <= 64'd0;
            dropped_reg  <= 32'd0;
            stolen_reg   <= 32'd0;
            active_reg   <= '0;
            cont_reg     <= '0;
            written_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            eval_vld_reg <= eval_vld_next;
            frame_reg    <= frame_next;
            dropped_reg  <= dropped_next;
            stolen_reg   <= stolen_next;
            active_reg   <= active_next;
            cont_reg     <= cont_next;
            written_reg  <= written_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        eval_idx_reg <= eval_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/vas_ram.sv =====
// voice state memory: one write port, one read port with registered data
// depends on vas_pkg
module vas_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [vas_pkg::VIDX_W-1:0] waddr,
    input  vas_pkg::voice_word_t      wdata,
    input  logic [vas_pkg::VIDX_W-1:0] raddr,
    output vas_pkg::voice_word_t      rdata
);
    import vas_pkg::*;

    voice_word_t mem [MAX_VOICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/vas_scan.sv =====
// shared scan unit: one voice per cycle while eval is high, for tag match, first free,
// quietest stealable voice and active count; depends on vas_pkg
module vas_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       eval,
    input  logic [vas_pkg::VIDX_W-1:0] idx,
    input  logic                       active,
    input  vas_pkg::voice_word_t       word,
    input  logic [31:0]                hint,
    input  logic [63:0]                frame,
    input  logic [31:0]                prot,
    output vas_pkg::scan_res_t         res
);
    import vas_pkg::*;

    scan_res_t res_reg, res_next;
    logic [63:0] age;
    logic        eligible;

    always_comb
    begin
        age      = frame - word.start_frame;
        eligible = age >= {32'd0, prot};
        res_next = res_reg;
        if (clear)
        begin
            res_next = '0;
        end
        else if (eval)
        begin
            if (hint != 32'd0 && active && word.tag == hint && !res_reg.match_found)
            begin
                res_next.match_found = 1'b1;
                res_next.match_idx   = idx;
            end
            if (!active && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = idx;
            end
            if (eligible && (!res_reg.quiet_found || word.energy < res_reg.quiet_energy))
            begin
                res_next.quiet_found  = 1'b1;
                res_next.quiet_idx    = idx;
                res_next.quiet_energy = word.energy;
            end
            if (active)
            begin
                res_next.active_cnt = res_reg.active_cnt + VCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== sv/vas_checker.sv =====
// port-level checks of the voice allocator with stealing, bound to the top
// depends on vas_pkg and voice_allocator_with_stealing
module vas_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  vas_pkg::in_t  cmd,
    input  logic          done,
    input  vas_pkg::out_t result
);
    import vas_pkg::*;

    // a result always leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // frame advance answers in the next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.mode == MODE_ADVANCE) |=>
        (done && result.status == ST_ADVANCED))
        else $error("advance did not complete in one cycle");

    // every transfer either completes at once or holds the block busy
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transfer lost");

    // dropped events show no voice
    a_dropped_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_NO_MODEL || result.status == ST_ALL_PROTECTED))
        |-> (result.tag_out == 32'd0 && result.voice_index == 6'd0))
        else $error("dropped event shows a voice");

endmodule

bind voice_allocator_with_stealing vas_checker u_vas_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

// ===== tb/voice_allocator_with_stealing_tb.sv =====
// self-checking testbench for the voice allocator with quietest-voice stealing
// depends on vas_pkg and voice_allocator_with_stealing; directed table, then random phases
module voice_allocator_with_stealing_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vas_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    in_t           cmd;
    logic          done;
    out_t          result;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_data;

    voice_allocator_with_stealing dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow copy of the config registers, the voice pool and the counters
    logic [15:0] near_cm, mid_cm, far_cm;
    logic [8:0]  press_q8;
    logic [31:0] counts_packed, protect_frames;
    logic [63:0] loaded_models;
    logic [6:0]  pool_reg;
    bit          v_act [MAX_VOICES];
    logic [31:0] v_tag [MAX_VOICES];
    logic [63:0] v_start [MAX_VOICES];
    logic [31:0] v_energy [MAX_VOICES];
    bit          v_cont [MAX_VOICES];
    logic [15:0] v_gain [MAX_VOICES];
    logic [15:0] v_pan [MAX_VOICES];
    logic [63:0] frame_now;
    logic [31:0] drop_cnt, steal_cnt;

    out_t pending_results[$];
    int   mismatches = 0;
    bit   quiet_tail = 0;

    function automatic int pool_voices();
        int n;
        n = int'(pool_reg);
        if (n < 1) n = 1;
        if (n > MAX_VOICES) n = MAX_VOICES;
        return n;
    endfunction

    function automatic out_t voice_view(status_t st, int idx, bit show, logic [7:0] modes);
        out_t r;
        r.status         = st;
        r.voice_index    = 6'(idx);
        r.tag_out        = show ? v_tag[idx] : 32'd0;
        r.mode_total     = modes;
        r.gain_q8        = show ? v_gain[idx] : 16'd0;
        r.pan_out_q15    = show ? v_pan[idx] : 16'd0;
        r.energy_out_q16 = show ? v_energy[idx] : 32'd0;
        r.dropped_total  = drop_cnt;
        r.stolen_total   = steal_cnt;
        return r;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic out_t allocate_voice(in_t c);
        int n, idx, busy_voices, band;
        logic [31:0] quietest;
        bit stole;
        out_t r;
        n = pool_voices();
        idx = -1;
        stole = 0;
        busy_voices = 0;
        quietest = 0;
        if (!loaded_models[c.model_sel])
        begin
            drop_cnt = bump(drop_cnt);
            return voice_view(ST_NO_MODEL, 0, 0, 8'd0);
        end
        if (c.contact_tag != 0)
            for (int i = 0; i < n; i++)
                if (v_act[i] && v_tag[i] == c.contact_tag)
                begin
                    if (c.contact_type == CONTACT_RELEASE)
                    begin
                        v_cont[i] = 0;
                        return voice_view(ST_RELEASED, i, 1, 8'd0);
                    end
                    v_gain[i] = c.force_q8;
                    v_pan[i] = c.pan_q15;
                    return voice_view(ST_REFRESHED, i, 1, 8'd0);
                end
        for (int i = 0; i < n; i++)
            if (!v_act[i] && idx < 0) idx = i;
        if (idx < 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (frame_now - v_start[i] < {32'd0, protect_frames}) continue;
                if (idx < 0 || v_energy[i] < quietest)
                begin
                    quietest = v_energy[i];
                    idx = i;
                end
            end
            if (idx < 0)
            begin
                drop_cnt = bump(drop_cnt);
                return voice_view(ST_ALL_PROTECTED, 0, 0, 8'd0);
            end
            stole = 1;
            steal_cnt = bump(steal_cnt);
        end
        for (int i = 0; i < n; i++) if (v_act[i]) busy_voices++;
        if (busy_voices * 256 > int'(press_q8) * n) band = 3;
        else if (c.distance_cm < near_cm) band = 0;
        else if (c.distance_cm < mid_cm) band = 1;
        else if (c.distance_cm < far_cm) band = 2;
        else band = 3;
        v_tag[idx] = c.contact_tag;
        v_start[idx] = frame_now;
        v_gain[idx] = UNITY_GAIN_Q8;
        v_pan[idx] = c.pan_q15;
        v_cont[idx] = (c.contact_type == CONTACT_ROLL || c.contact_type == CONTACT_SCRAPE);
        v_energy[idx] = (c.impulse_q16 > ENERGY_FLOOR_Q16) ? c.impulse_q16 : ENERGY_FLOOR_Q16;
        v_act[idx] = 1;
        r = voice_view(stole ? ST_STOLEN : ST_NEW_FREE, idx, 1, counts_packed[8*band +: 8]);
        r.tag_out = (c.contact_tag != 0) ? c.contact_tag : 32'd1;
        return r;
    endfunction

    function automatic out_t predict_result(in_t c);
        int sel;
        status_t st;
        out_t r;
        sel = int'(c.voice_select);
        case (mode_t'(c.mode))
            MODE_CONTACT: return allocate_voice(c);
            MODE_ADVANCE:
            begin
                frame_now = frame_now + {48'd0, c.frame_step};
                return voice_view(ST_ADVANCED, 0, 0, 8'd0);
            end
            default: ;
        endcase
        st = (c.mode == MODE_ENERGY) ? ST_ENERGY : ST_RETIRED;
        if (sel >= pool_voices())
        begin
            r = voice_view(st, 0, 0, 8'd0);
            r.voice_index = c.voice_select;
            return r;
        end
        if (c.mode == MODE_ENERGY)
        begin
            if (v_act[sel])
            begin
                v_energy[sel] = c.energy_q16;
                if (!v_cont[sel] && c.energy_q16 < SILENCE_LEVEL_Q16)
                begin
                    v_act[sel] = 0;
                    st = ST_SILENCED;
                end
            end
        end
        else
            v_act[sel] = 0;
        return voice_view(st, sel, 1, 8'd0);
    endfunction

    function automatic void apply_register(cfg_idx_t idx, logic [63:0] d);
        case (idx)
            CFG_NEAR:      near_cm = d[15:0];
            CFG_MID:       mid_cm = d[15:0];
            CFG_FAR:       far_cm = d[15:0];
            CFG_PRESSURE:  press_q8 = d[8:0];
            CFG_COUNTS:    counts_packed = d[31:0];
            CFG_MODELS:    loaded_models = d;
            CFG_PROTECTED: protect_frames = d[31:0];
            CFG_VCOUNT:    pool_reg = d[6:0];
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10) $display("unexpected result %p", result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status || result.voice_index !== want.voice_index
                    || result.tag_out !== want.tag_out || result.mode_total !== want.mode_total
                    || result.gain_q8 !== want.gain_q8 || result.pan_out_q15 !== want.pan_out_q15
                    || result.energy_out_q16 !== want.energy_out_q16
                    || result.dropped_total !== want.dropped_total
                    || result.stolen_total !== want.stolen_total)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p actual %p", want, result);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_item(in_t c, bit typed, out_t typed_exp);
        out_t pred;
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        cmd <= c;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        pred = predict_result(c);
        pending_results.push_back(typed ? typed_exp : pred);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [63:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_t make_cmd(mode_t m, logic [5:0] model, logic [31:0] hint,
                                     logic [1:0] ctype, logic [15:0] range_cm,
                                     logic [15:0] pan, logic [15:0] force_g, logic [31:0] imp,
                                     logic [5:0] sel, logic [31:0] en, logic [15:0] step);
        in_t c;
        c.mode = m;
        c.model_sel = model;
        c.contact_tag = hint;
        c.contact_type = ctype;
        c.distance_cm = range_cm;
        c.pan_q15 = pan;
        c.force_q8 = force_g;
        c.impulse_q16 = imp;
        c.voice_select = sel;
        c.energy_q16 = en;
        c.frame_step = step;
        return c;
    endfunction

    function automatic in_t random_cmd();
        in_t c;
        int pick;
        logic [191:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = bits[$bits(in_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 65) c.mode = MODE_CONTACT;
        else if (pick < 80) c.mode = MODE_ENERGY;
        else if (pick < 87) c.mode = MODE_RETIRE;
        else c.mode = MODE_ADVANCE;
        pick = $urandom_range(0, 9);
        if (pick == 0) c.contact_tag = 32'd0;
        else if (pick < 9) c.contact_tag = $urandom_range(1, 6);
        if ($urandom_range(0, 2) != 0) c.energy_q16 = $urandom_range(0, 12);
        if ($urandom_range(0, 3) != 0) c.voice_select = 6'($urandom_range(0, 9));
        if ($urandom_range(0, 9) != 0) c.frame_step = 16'($urandom_range(0, 700));
        return c;
    endfunction

    typedef struct {
        bit          is_cfg;
        cfg_idx_t    reg_sel;
        logic [63:0] reg_val;
        in_t         item;
        bit          typed;
        out_t        typed_exp;
    } step_row_t;

    step_row_t script[$];

    function automatic void add_item(in_t c);
        step_row_t s;
        s = '{0, CFG_NEAR, 64'd0, c, 0, '0};
        script.push_back(s);
    endfunction

    function automatic void add_typed(in_t c, out_t e);
        step_row_t s;
        s = '{0, CFG_NEAR, 64'd0, c, 1, e};
        script.push_back(s);
    endfunction

    function automatic void add_cfg(cfg_idx_t idx, logic [63:0] d);
        step_row_t s;
        s = '{1, idx, d, '0, 0, '0};
        script.push_back(s);
    endfunction

    function automatic logic [63:0] pick_extreme(logic [63:0] lo, logic [63:0] hi,
                                                 logic [63:0] rnd);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return rnd;
        endcase
    endfunction

    initial
    begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int phase_items;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NEAR;
        cfg_data = '0;
        near_cm = 16'd500;
        mid_cm = 16'd2000;
        far_cm = 16'd5000;
        press_q8 = 9'd230;
        counts_packed = 32'd135274560;
        loaded_models = '0;
        protect_frames = 32'd480;
        pool_reg = 7'd64;
        frame_now = '0;
        drop_cnt = '0;
        steal_cnt = '0;
        for (int i = 0; i < MAX_VOICES; i++)
        begin
            v_act[i] = 0; v_tag[i] = 0; v_start[i] = 0; v_energy[i] = 0;
            v_cont[i] = 0; v_gain[i] = 0; v_pan[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing loaded yet: a drop, a frame advance and reads of empty voices
        add_typed(make_cmd(MODE_CONTACT, 6'd0, 32'd3, 2'd0, 16'd0, 16'd0, 16'd0, 32'd9,
                           6'd0, 32'd0, 16'd0),
                  '{ST_NO_MODEL, 6'd0, 32'd0, 8'd0, 16'd0, 16'sd0, 32'd0, 32'd1, 32'd0});
        add_typed(make_cmd(MODE_ADVANCE, 6'd63, 32'd0, 2'd3, 16'd0, 16'd0, 16'd0, 32'd0,
                           6'd0, 32'd0, 16'hFFFF),
                  '{ST_ADVANCED, 6'd0, 32'd0, 8'd0, 16'd0, 16'sd0, 32'd0, 32'd1, 32'd0});
        add_typed(make_cmd(MODE_ENERGY, 6'd0, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                           6'd63, 32'hFFFF_FFFF, 16'd0),
                  '{ST_ENERGY, 6'd63, 32'd0, 8'd0, 16'd0, 16'sd0, 32'd0, 32'd1, 32'd0});
        add_typed(make_cmd(MODE_RETIRE, 6'd0, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                           6'd0, 32'd0, 16'd0),
                  '{ST_RETIRED, 6'd0, 32'd0, 8'd0, 16'd0, 16'sd0, 32'd0, 32'd1, 32'd0});
        add_cfg(CFG_MODELS, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(CFG_VCOUNT, 64'd4);
        add_cfg(CFG_PROTECTED, 64'hFFFF_FFFF);
        add_item(make_cmd(MODE_CONTACT, 6'd63, 32'd5, CONTACT_ROLL, 16'd0, 16'h8000, 16'd0,
                          32'd0, 6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd63, 32'd5, 2'd0, 16'd0, 16'h7FFF, 16'hFFFF,
                          32'd0, 6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd63, 32'd5, CONTACT_RELEASE, 16'd0, 16'd0, 16'd0,
                          32'd0, 6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd1, 32'd0, CONTACT_RELEASE, 16'hFFFF, 16'd0,
                          16'd0, 32'hFFFF_FFFF, 6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd2, 32'd9, CONTACT_SCRAPE, 16'd1999, 16'd5, 16'd0,
                          32'd100, 6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd3, 32'hFFFF_FFFF, 2'd0, 16'd4999, 16'd0, 16'd0,
                          32'd7, 6'd0, 32'd0, 16'd0));
        // pool full and every voice protected: drop
        add_typed(make_cmd(MODE_CONTACT, 6'd4, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd1,
                           6'd0, 32'd0, 16'd0),
                  '{ST_ALL_PROTECTED, 6'd0, 32'd0, 8'd0, 16'd0, 16'sd0, 32'd0, 32'd2, 32'd0});
        add_item(make_cmd(MODE_ENERGY, 6'd0, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                          6'd63, 32'd0, 16'd0));
        add_item(make_cmd(MODE_ENERGY, 6'd0, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                          6'd1, 32'd6, 16'd0));
        add_item(make_cmd(MODE_ENERGY, 6'd0, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                          6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_RETIRE, 6'd0, 32'd0, 2'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                          6'd2, 32'd0, 16'd0));
        add_cfg(CFG_PROTECTED, 64'd0);
        add_item(make_cmd(MODE_CONTACT, 6'd5, 32'd11, 2'd0, 16'd10, 16'd0, 16'd0, 32'd50,
                          6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd5, 32'd12, 2'd0, 16'd10, 16'd0, 16'd0, 32'd50,
                          6'd0, 32'd0, 16'd0));
        add_item(make_cmd(MODE_CONTACT, 6'd5, 32'd13, 2'd0, 16'd10, 16'd0, 16'd0, 32'd50,
                          6'd0, 32'd0, 16'd0));
        add_cfg(CFG_VCOUNT, 64'd0);
        add_item(make_cmd(MODE_CONTACT, 6'd6, 32'd14, 2'd0, 16'd10, 16'd0, 16'd0, 32'd2,
                          6'd0, 32'd0, 16'd0));

        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                drain_results();
                write_register(script[k].reg_sel, script[k].reg_val);
            end
            else
                send_item(script[k].item, script[k].typed, script[k].typed_exp);
        end

        // random phases, each under a fresh register setting; the drain before
        // each setting is also the sender waiting for every result
        for (int phase = 0; phase < 10; phase++)
        begin
            drain_results();
            write_register(CFG_NEAR, pick_extreme(64'd0, 64'hFFFF,
                           64'($urandom_range(0, 3000))));
            write_register(CFG_MID, pick_extreme(64'd0, 64'hFFFF,
                           64'($urandom_range(0, 8000))));
            write_register(CFG_FAR, pick_extreme(64'd0, 64'hFFFF,
                           64'($urandom_range(0, 65535))));
            write_register(CFG_PRESSURE, pick_extreme(64'd0, 64'd256,
                           64'($urandom_range(0, 511))));
            write_register(CFG_COUNTS, {32'd0, $urandom});
            write_register(CFG_MODELS, ($urandom_range(0, 3) == 0) ?
                           {$urandom, $urandom} : ~(64'd1 << $urandom_range(0, 63)));
            write_register(CFG_PROTECTED, pick_extreme(64'd0, 64'hFFFF_FFFF,
                           ($urandom_range(0, 1) == 0) ? 64'($urandom_range(1, 2000))
                                                       : 64'($urandom)));
            case (phase % 5)
                0: write_register(CFG_VCOUNT, 64'd64);
                1: write_register(CFG_VCOUNT, 64'd1);
                2: write_register(CFG_VCOUNT, ($urandom_range(0, 1) == 0) ? 64'd0 : 64'd127);
                default: write_register(CFG_VCOUNT, 64'($urandom_range(2, 8)));
            endcase
            phase_items = (pool_reg >= 16) ? 110 : 170;
            if (phase == 9) quiet_tail = 1;
            for (int k = 0; k < phase_items; k++)
                send_item(random_cmd(), 0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/vas_pkg.sv
sv/vas_ram.sv
sv/vas_scan.sv
sv/voice_allocator_with_stealing.sv
sv/vas_checker.sv
tb/voice_allocator_with_stealing_tb.sv
